[rtl/ghash_pkg.sv]
package ghash_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned HALF_W = 64;

  // Default number of key-multiplier steps per cycle
  localparam int unsigned DIGIT_BITS_DEF = 8;

  // x^128 + x^7 + x^2 + x + 1 folded back for a one-bit right shift (reflected order)
  localparam logic [BLOCK_W-1:0] GF_REDUCE = {8'hE1, 120'h0};

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_ABSORB = 1'b1;

endpackage

[rtl/ghash_gf128_accumulate.sv]
// Load item: the block goes straight into the output register, or waits in the
// accumulator (ST_PEND) while that register is still held; the input is ready again
// once it is placed. Absorb item: ceil(128/DIGIT_BITS) digit steps in the digit-serial
// GF(2^128) multiplier (16 at DIGIT_BITS = 8); the input is held off while it runs and
// until the product is placed in the output register, so absorbs do not overlap.
// Reset (rst_ni low, async): accumulator and hash key clear to zero, output empty.
module ghash_gf128_accumulate
  import ghash_pkg::*;
#(
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [HALF_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [BLOCK_W-1:0]   s_axis_tdata,  // block_high [63:0], block_low [127:64]
  input  logic                 s_axis_tuser,  // req_type
  input  logic                 s_axis_tlast,  // last_block
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [BLOCK_W-1:0]   m_axis_tdata,  // digest_high [63:0], digest_low [127:64]
  output logic                 m_axis_tlast   // run_done
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_PEND = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [BLOCK_W-1:0] key_q;
  logic [BLOCK_W-1:0] accum_q, accum_d;
  logic [BLOCK_W-1:0] out_q, out_d;
  logic               out_vld_q, out_vld_d;
  logic               out_last_q, out_last_d;
  logic               last_q, last_d;
  logic [BLOCK_W-1:0] blk;
  logic               in_xfer;
  logic               out_free;
  logic               mul_start;
  logic               mul_done;
  logic [BLOCK_W-1:0] mul_z;

  assign blk      = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[BLOCK_W-1:HALF_W]};
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign mul_start     = in_xfer && (s_axis_tuser == REQ_ABSORB);

  ghash_mul #(
    .DIGIT_BITS(DIGIT_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .x_i    (accum_q ^ blk),
    .h_i    (key_q),
    .done_o (mul_done),
    .z_o    (mul_z)
  );

  always_comb begin
    state_d    = state_q;
    accum_d    = accum_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    last_d     = last_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          last_d = s_axis_tlast;
          if (s_axis_tuser == REQ_ABSORB) begin
            state_d = ST_MUL;
          end else begin
            accum_d = blk;
            if (out_free) begin
              out_d      = blk;
              out_last_d = s_axis_tlast;
              out_vld_d  = 1'b1;
            end else begin
              state_d = ST_PEND;
            end
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          accum_d = mul_z;
          if (out_free) begin
            out_d      = mul_z;
            out_last_d = last_q;
            out_vld_d  = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_PEND;
          end
        end
      end
      ST_PEND: begin
        // hold the result in the accumulator until the output register drains
        if (out_free) begin
          out_d      = accum_q;
          out_last_d = last_q;
          out_vld_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      accum_q   <= '0;
      key_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      accum_q   <= accum_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_KEY_HIGH: key_q[BLOCK_W-1:HALF_W] <= cfg_data_i;
          REG_KEY_LOW:  key_q[HALF_W-1:0] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    out_last_q <= out_last_d;
    last_q     <= last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q[HALF_W-1:0], out_q[BLOCK_W-1:HALF_W]};
  assign m_axis_tlast  = out_last_q;

endmodule

[rtl/ghash_mul.sv]
module ghash_mul
  import ghash_pkg::*;
#(
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [BLOCK_W-1:0] x_i,
  input  logic [BLOCK_W-1:0] h_i,
  output logic               done_o,
  output logic [BLOCK_W-1:0] z_o
);

  localparam int unsigned NCYC = (BLOCK_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned CNT_W = $clog2(NCYC + 1);
  localparam logic [CNT_W-1:0] NCYC_C = CNT_W'(NCYC);

  logic [BLOCK_W-1:0] x_q, x_d;
  logic [BLOCK_W-1:0] v_q, v_d;
  logic [BLOCK_W-1:0] r_q, r_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // One digit of X per cycle, MSB first; V walks through H times x^k.
  // Bits past the end of X are zeros, so a short final digit leaves R alone.
  always_comb begin
    logic carry;
    x_d   = x_q;
    v_d   = v_q;
    r_d   = r_q;
    cnt_d = cnt_q;
    carry = 1'b0;
    if (start_i) begin
      x_d   = x_i;
      v_d   = h_i;
      r_d   = '0;
      cnt_d = NCYC_C;
    end else if (cnt_q != '0) begin
      for (int d = 0; d < DIGIT_BITS; d++) begin
        if (x_d[BLOCK_W-1]) begin
          r_d = r_d ^ v_d;
        end
        x_d   = {x_d[BLOCK_W-2:0], 1'b0};
        carry = v_d[0];
        v_d   = {1'b0, v_d[BLOCK_W-1:1]} ^ (carry ? GF_REDUCE : '0);
      end
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    v_q <= v_d;
    r_q <= r_d;
  end

  // Product is ready on the last digit cycle
  assign done_o = (cnt_q == CNT_W'(1));
  assign z_o    = r_d;

endmodule

[rtl/ghash_checker.sv]
module ghash_props
  import ghash_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [BLOCK_W-1:0]   s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [BLOCK_W-1:0]   m_axis_tdata,
  input logic                 m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // an absorb occupies the multiplier, so no item follows right away
  a_absorb_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_ABSORB) |=> !s_axis_tready)
    else $error("input taken while multiplier busy");

  // a load with a free output slot shows its block as the digest next cycle
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD) &&
      (!m_axis_tvalid || m_axis_tready) |=>
      m_axis_tvalid && (m_axis_tdata == $past(s_axis_tdata)) &&
      (m_axis_tlast == $past(s_axis_tlast)))
    else $error("load result mismatch");

endmodule

bind ghash_gf128_accumulate ghash_props u_ghash_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
